// File: rtl/core/lpht_pkg.sv
// ============================================================================
// lpht_pkg - shared definitions of the linear probe hash table
// Field widths, operation and status codes, slot states and defaults.
// ============================================================================
package lpht_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CFG_W    = 9;
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 31;
  localparam int STATUS_W = 3;
  localparam int PROBE_W  = 9;
  localparam int COUNT_W  = 9;
  localparam int SLOT_W   = 2;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 9'd256;

  // Modulo unit: dividend padded to MOD_BITS * MOD_STEPS bits.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = 8;
  localparam int MOD_PAD_W = MOD_BITS * MOD_STEPS;

  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRAP     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_OCC   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DEL   = 2'd2;

endpackage

// File: rtl/core/linear_probe_hash_table_top.sv
// ============================================================================
// linear_probe_hash_table_top - open-addressed hash table, linear probing
// Find, insert and erase on 31-bit keys with tombstones on erase.
// ============================================================================
// Usage:
//   Requests enter on the in_valid/in_ready channel (kind, key, value) and
//   every request returns exactly one item on out_valid/out_ready (status,
//   probe_count). The table size register is written through cfg_valid /
//   cfg_ready with table_size as data; write it only while the block is idle
//   and reset the block after changing it.
//   Flow: a request that needs no walk (full insert, erase on an empty
//   table, unknown kind) goes from acceptance straight to S_FIN, where its
//   result is loaded. A walking request passes the shared modulo unit (4 key
//   bits per cycle), the hand-over of the home slot, S_ISSUE to start the
//   first slot memory read, S_CHK for each slot probed, and S_FIN to load
//   the result. The block takes one request at a time: it accepts the
//   next one only when it is back in S_IDLE.
//   Reset: rst is synchronous. After it the slot state memory is cleared in a
//   pass over all TABLE_DEPTH slots during which in_ready stays low;
//   configuration writes are taken at all times.
//   Stalls: a result waits in the output register while out_ready is low; the
//   next request can be accepted meanwhile, and it waits for the register
//   before its own result is loaded.
// ============================================================================
module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    table_size,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [VAL_W-1:0]    value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [PROBE_W-1:0]  probe_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = IW + 1;
  localparam int EW = KEY_W + VAL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ISSUE,
    S_CHK,
    S_FIN
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    size_reg;
  logic [SW-1:0]       eff_size;
  logic [COUNT_W-1:0]  entry_count;

  // Request held for the walk.
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    value_q;

  logic [IW-1:0]       home;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       idx_inc;
  logic [SW-1:0]       idx_plus;
  logic [PROBE_W-1:0]  probes;
  logic                first;
  logic [IW-1:0]       clr_idx;

  logic [STATUS_W-1:0] res_status;
  logic [PROBE_W-1:0]  res_probes;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                mod_start;
  logic                mod_done;
  logic [SW-1:0]       mod_rem;

  logic                st_we;
  logic [IW-1:0]       st_waddr;
  logic [SLOT_W-1:0]   st_wdata;
  logic [SLOT_W-1:0]   st_rdata;
  logic                ent_we;
  logic [IW-1:0]       raddr;
  logic [EW-1:0]       ent_rdata;

  logic                slot_occ;
  logic                key_hit;
  logic                wrapped;
  logic                out_free;

  // The register takes writes at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= TABLE_SIZE_RESET;
    end else if (cfg_valid) begin
      size_reg <= table_size;
    end
  end

  // A size of zero works as one slot; anything above the memory saturates.
  always_comb begin
    if (size_reg == '0) begin
      eff_size = SW'(1);
    end else if (32'(size_reg) > TABLE_DEPTH) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = SW'(size_reg);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_full   = 32'(entry_count) >= 32'(eff_size);
  assign is_empty  = (entry_count == '0);

  // Only requests that walk the table need the home slot.
  always_comb begin
    unique case (kind)
      KIND_FIND:   mod_start = accept;
      KIND_INSERT: mod_start = accept && !is_full;
      KIND_ERASE:  mod_start = accept && !is_empty;
      default:     mod_start = 1'b0;
    endcase
  end

  lpht_mod_unit #(
    .SIZE_W (SW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (key),
    .divisor   (eff_size),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Next probe slot, wrapping at the effective size.
  assign idx_plus = {1'b0, idx} + SW'(1);
  assign idx_inc  = (idx_plus == eff_size) ? '0 : idx_plus[IW-1:0];

  // While checking one slot, the read of the following slot is already out.
  assign raddr = (state == S_CHK) ? idx_inc : idx;

  assign slot_occ = (st_rdata == SLOT_OCC);
  assign key_hit  = slot_occ && (ent_rdata[EW-1:VAL_W] == key_q);
  assign wrapped  = (idx == home) && !first;
  assign out_free = !out_valid || out_ready;

  // Slot state writes: the clearing pass, an insert into a free slot or an erase hit.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx;
    st_wdata = SLOT_OCC;
    ent_we   = 1'b0;
    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_idx;
      st_wdata = SLOT_EMPTY;
    end else if (state == S_CHK) begin
      if (kind_q == KIND_INSERT) begin
        st_we  = !slot_occ;
        ent_we = !slot_occ;
      end else if (kind_q == KIND_ERASE) begin
        st_we    = key_hit;
        st_wdata = SLOT_DEL;
      end
    end
  end

  lpht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  // Keys and values share one memory; only the key half of the read data is used.
  lpht_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (idx),
    .wdata ({key_q, value_q}),
    .raddr (raddr),
    .rdata (ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A result loaded in S_FIN takes over the register instead.
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q  <= kind;
            key_q   <= key;
            value_q <= value;
            if (mod_start) begin
              state <= S_MOD;
            end else begin
              // Requests answered without touching the slots.
              res_probes <= '0;
              if (kind == KIND_INSERT) begin
                res_status <= ST_FULL;
              end else if (kind == KIND_ERASE) begin
                res_status <= ST_EMPTY;
              end else begin
                res_status <= ST_NOTFOUND;
              end
              state <= S_FIN;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            home   <= mod_rem[IW-1:0];
            idx    <= mod_rem[IW-1:0];
            probes <= PROBE_W'(1);
            first  <= 1'b1;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (kind_q == KIND_INSERT) begin
            if (!slot_occ) begin
              res_status  <= ST_DONE;
              res_probes  <= probes;
              entry_count <= entry_count + COUNT_W'(1);
              state       <= S_FIN;
            end else if (wrapped) begin
              res_status <= ST_WRAP;
              res_probes <= probes;
              state      <= S_FIN;
            end else begin
              idx    <= idx_inc;
              probes <= probes + PROBE_W'(1);
              first  <= 1'b0;
            end
          end else begin
            if (st_rdata == SLOT_EMPTY) begin
              res_status <= ST_NOTFOUND;
              res_probes <= probes;
              state      <= S_FIN;
            end else if (key_hit) begin
              res_status <= ST_DONE;
              res_probes <= probes;
              if (kind_q == KIND_ERASE) begin
                entry_count <= entry_count - COUNT_W'(1);
              end
              state <= S_FIN;
            end else if (wrapped) begin
              res_status <= ST_WRAP;
              res_probes <= probes;
              state      <= S_FIN;
            end else begin
              idx    <= idx_inc;
              probes <= probes + PROBE_W'(1);
              first  <= 1'b0;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            status      <= res_status;
            probe_count <= res_probes;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/lpht_ram.sv
// ============================================================================
// lpht_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/lpht_mod_unit.sv
// ============================================================================
// lpht_mod_unit - iterative key modulo table size
// Restoring remainder, MOD_BITS dividend bits per cycle over MOD_STEPS steps.
// ============================================================================
module lpht_mod_unit import lpht_pkg::*; #(
  parameter int SIZE_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] remainder
);

  localparam int CNT_W = $clog2(MOD_STEPS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [MOD_PAD_W-1:0] shreg;
  logic [SIZE_W-1:0]    rem_next;

  // Each bit step keeps the partial remainder below the divisor.
  always_comb begin
    logic [SIZE_W:0] r;
    r = {1'b0, remainder};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[SIZE_W-1:0], shreg[MOD_PAD_W-1-i]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next = r[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(MOD_STEPS - 1));
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        shreg     <= MOD_PAD_W'(dividend);
        remainder <= '0;
      end else if (busy) begin
        remainder <= rem_next;
        shreg     <= shreg << MOD_BITS;
        cnt       <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/core/lpht_checker.sv
// ============================================================================
// lpht_checker - port-level assertions for the hash table
// Watches the channels of the top level and is bound to it.
// ============================================================================
module lpht_checker import lpht_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [PROBE_W-1:0]  probe_count
);

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(probe_count))
    else $error("result changed while stalled");

  // Reset starts the clearing pass with no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block ready or result pending right after reset");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // Full and empty answers carry no probes; a successful request probed at least one slot.
  a_probe_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EMPTY) |-> probe_count == '0)
    else $error("full or empty answer with nonzero probe count");

  a_hit_probed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DONE |-> probe_count != '0)
    else $error("successful request with zero probe count");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);

// File: sim/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_hash_table_top_tb - self-checking bench for the hash table
// Drives find, insert, erase and unused-kind items on the request channel,
// predicts every response with a cycle-free model of the slot table, and
// compares status and probe count of each response in order. Both channels
// see random gaps, one long output stall fills the block, and the table
// size is swept across its extremes with the table drained between settings.
// ============================================================================
module linear_probe_hash_table_top_tb;
  import lpht_pkg::*;

  localparam int          DEPTH        = TABLE_DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          N_PHASES     = 11;
  localparam int          POOL_SIZE    = 16;
  localparam int          HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 6_000_000;

  // One expected response.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PROBE_W-1:0]  probes;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the slot table and the size register,
  // works out the response of each accepted item and checks responses in
  // order. Stored values are never visible at the outputs, so only the slot
  // states and keys are tracked.
  // --------------------------------------------------------------------------
  class hash_table_checker;
    logic [CFG_W-1:0]  size_reg;
    logic [SLOT_W-1:0] slot_state [DEPTH];
    logic [KEY_W-1:0]  slot_key   [DEPTH];
    int unsigned       entry_count;
    answer_t           pending_answers [$];
    int unsigned       errors;

    function new();
      size_reg = TABLE_SIZE_RESET;
      foreach (slot_state[i]) begin
        slot_state[i] = SLOT_EMPTY;
        slot_key[i]   = '0;
      end
      entry_count = 0;
      errors      = 0;
    endfunction

    // Zero is taken as one slot, anything above the depth saturates.
    function int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return size_reg;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    // Search walk shared by find and erase: stops at an empty slot, at a
    // matching occupied slot, or when it comes back around to the home slot.
    function void search_chain(input logic [KEY_W-1:0] ky, input int unsigned s,
                               output logic [STATUS_W-1:0] st,
                               output int unsigned n, output int unsigned hit);
      int unsigned home;
      int unsigned idx;
      bit          first;
      bit          done;
      home  = ky % s;
      idx   = home;
      n     = 1;
      hit   = 0;
      first = 1'b1;
      done  = 1'b0;
      st    = ST_NOTFOUND;
      while (!done) begin
        if (slot_state[idx] == SLOT_EMPTY) begin
          st   = ST_NOTFOUND;
          done = 1'b1;
        end else if (slot_state[idx] == SLOT_OCC && slot_key[idx] == ky) begin
          st   = ST_DONE;
          hit  = idx;
          done = 1'b1;
        end else if (idx == home && !first) begin
          st   = ST_WRAP;
          done = 1'b1;
        end else begin
          n++;
          first = 1'b0;
          idx   = (idx + 1 >= s) ? 0 : idx + 1;
        end
      end
    endfunction

    function void accept_request(logic [KIND_W-1:0] k, logic [KEY_W-1:0] ky);
      answer_t             a;
      logic [STATUS_W-1:0] st;
      int unsigned         s;
      int unsigned         n;
      int unsigned         hit;
      int unsigned         home;
      int unsigned         idx;
      bit                  first;
      s  = active_size();
      n  = 0;
      st = ST_NOTFOUND;
      case (k)
        KIND_FIND: begin
          search_chain(ky, s, st, n, hit);
        end
        KIND_INSERT: begin
          if (entry_count >= s) begin
            st = ST_FULL;
          end else begin
            // First slot that is not occupied wins; tombstones are reused.
            home  = ky % s;
            idx   = home;
            n     = 1;
            first = 1'b1;
            st    = ST_DONE;
            while (slot_state[idx] == SLOT_OCC && st == ST_DONE) begin
              if (idx == home && !first) begin
                st = ST_WRAP;
              end else begin
                n++;
                first = 1'b0;
                idx   = (idx + 1 >= s) ? 0 : idx + 1;
              end
            end
            if (st == ST_DONE) begin
              slot_state[idx] = SLOT_OCC;
              slot_key[idx]   = ky;
              entry_count++;
            end
          end
        end
        KIND_ERASE: begin
          if (entry_count == 0) begin
            st = ST_EMPTY;
          end else begin
            search_chain(ky, s, st, n, hit);
            if (st == ST_DONE) begin
              slot_state[hit] = SLOT_DEL;
              slot_key[hit]   = '0;
              entry_count--;
            end
          end
        end
        default: begin
          // The unused kind code is answered as not found with no probes.
          st = ST_NOTFOUND;
          n  = 0;
        end
      endcase
      a.status = st;
      a.probes = n[PROBE_W-1:0];
      pending_answers.push_back(a);
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [PROBE_W-1:0] pc);
      answer_t a;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: response with none expected: status %0d probe_count %0d",
                 $time, st, pc);
        return;
      end
      a = pending_answers.pop_front();
      if (st !== a.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, a.status, st);
      end
      if (pc !== a.probes) begin
        errors++;
        $display("%0t: probe_count expected %0d actual %0d", $time, a.probes, pc);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    table_size  = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind        = KIND_FIND;
  logic [KEY_W-1:0]    key         = '0;
  logic [VAL_W-1:0]    value       = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PROBE_W-1:0]  probe_count;

  hash_table_checker sb;

  // When calm is set both sides run without gaps; hold_output asks the
  // response side for one long stall.
  bit          calm        = 1'b0;
  bit          hold_output = 1'b0;
  int unsigned cycles      = 0;

  // Table sizes swept by the random part: exact depth, the smallest sizes,
  // odd sizes, oversized values that saturate and zero.
  logic [CFG_W-1:0] phase_sizes [N_PHASES] = '{
    9'd256, 9'd1, 9'd7, 9'd2, 9'd300, 9'd16, 9'd3, 9'd64, 9'd0, 9'd257, 9'd255
  };

  always #6 clk = ~clk;

  linear_probe_hash_table_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .table_size  (table_size),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .probe_count (probe_count)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid is raised with the payload at a clock edge and held
  // until the edge where in_ready is seen high; the item is handed to the
  // scoreboard at that edge. With no gap the next item follows at once, so
  // valid is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] ky,
                              input logic [VAL_W-1:0] v);
    int unsigned gap;
    in_valid <= 1'b1;
    kind     <= k;
    key      <= ky;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_request(k, ky);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every expected response has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] v);
    cfg_valid  <= 1'b1;
    table_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(v);
    cfg_valid <= 1'b0;
  endtask

  // Erases every stored key so that a new size starts from a table with no
  // entries (tombstones stay behind), then waits for the block to go idle.
  // Entries always sit inside the current size here, so each erase finds one.
  task automatic drain_table();
    logic [KEY_W-1:0] keys [$];
    for (int i = 0; i < DEPTH; i++) begin
      if (sb.slot_state[i] == SLOT_OCC) keys.push_back(sb.slot_key[i]);
    end
    foreach (keys[i]) send_request(KIND_ERASE, keys[i], 31'($urandom));
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready toggles with random busy and stall stretches. When
  // the request side asks for it, ready is held low in one long stall so that
  // the output register and the pending request fill and in_ready drops.
  // --------------------------------------------------------------------------
  initial begin : response_side
    int unsigned busy;
    int unsigned gap;
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        busy = $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (busy) @(posedge clk);
        gap = pick_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Responses are taken at the edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_response(status, probe_count);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("linear_probe_hash_table_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [KEY_W-1:0] pool [POOL_SIZE];
    logic [KEY_W-1:0] ky;
    logic [KIND_W-1:0] k;
    int unsigned       s;
    int unsigned       r;
    int unsigned       per_phase;
    sb        = new();
    per_phase = RANDOM_ITEMS / N_PHASES;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size: erase on an empty table, a miss,
    // extreme keys and values, a duplicate key, a hit behind a tombstone,
    // the unused kind code and reuse of a tombstone by an insert.
    send_request(KIND_ERASE,  31'd7,          31'd0);
    send_request(KIND_FIND,   31'd0,          31'd0);
    send_request(KIND_INSERT, 31'd0,          31'h7FFF_FFFF);
    send_request(KIND_INSERT, 31'h7FFF_FFFF,  31'd0);
    send_request(KIND_INSERT, 31'd0,          31'd1);
    send_request(KIND_FIND,   31'h7FFF_FFFF,  31'd0);
    send_request(KIND_FIND,   31'd0,          31'd0);
    send_request(KIND_ERASE,  31'd0,          31'd0);
    send_request(KIND_FIND,   31'd0,          31'd0);
    send_request(KIND_UNUSED, 31'h7FFF_FFFF,  31'h7FFF_FFFF);
    send_request(KIND_INSERT, 31'd256,        31'h2AAA_AAAA);
    drain_table();

    // A size of zero acts as a single slot: full insert, a miss that wraps
    // the whole table, a wrap over a tombstone and erase on an empty table.
    write_table_size(9'd0);
    send_request(KIND_INSERT, 31'd5,          31'h5555_5555);
    send_request(KIND_INSERT, 31'd9,          31'd3);
    send_request(KIND_FIND,   31'd6,          31'd0);
    send_request(KIND_ERASE,  31'd5,          31'd0);
    send_request(KIND_FIND,   31'd5,          31'd0);
    send_request(KIND_ERASE,  31'd5,          31'd0);
    send_request(KIND_INSERT, 31'd3,          31'd0);
    drain_table();

    // The largest register value saturates to the full depth.
    write_table_size(9'd511);
    send_request(KIND_FIND,   31'h5555_5555,  31'd0);
    send_request(KIND_INSERT, 31'h2AAA_AAAA,  31'h5555_5555);
    send_request(KIND_INSERT, 31'h5555_5555,  31'h2AAA_AAAA);
    send_request(KIND_FIND,   31'h2AAA_AAAA,  31'd0);

    // Random part, one phase per table size. Half of each key pool clusters
    // on the first few home slots to build long probe chains; the other half
    // spans the full key range.
    for (int p = 0; p < N_PHASES; p++) begin
      drain_table();
      write_table_size(phase_sizes[p]);
      s = sb.active_size();
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (i % 2 == 0) pool[i] = 31'(s * $urandom_range(0, 8388607) + $urandom_range(0, 3));
        else            pool[i] = 31'($urandom);
      end
      for (int i = 0; i < per_phase; i++) begin
        if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == 0 && i == 40) hold_output = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 40)      k = KIND_INSERT;
        else if (r < 70) k = KIND_FIND;
        else if (r < 95) k = KIND_ERASE;
        else             k = KIND_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 65)      ky = pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 85) ky = 31'($urandom_range(0, 4 * s));
        else             ky = 31'($urandom);
        send_request(k, ky, 31'($urandom));
      end
    end
    calm = 1'b0;

    // Wait for the last responses, and then for anything stray.
    wait_idle();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("linear_probe_hash_table_top verification clean");
    end else begin
      $display("linear_probe_hash_table_top verification failed");
    end
    $finish;
  end

endmodule
